FILE: rtl/tmcr_pkg.sv
// Package with the beat types, item kinds and register indexes of the text cell renderer.
package tmcr_pkg;

  localparam logic [1:0] KIND_FONT_WRITE = 2'd0;
  localparam logic [1:0] KIND_CELL_WRITE = 2'd1;
  localparam logic [1:0] KIND_PIXEL_QUERY = 2'd2;
  localparam logic [1:0] KIND_DIRTY_SCAN = 2'd3;

  localparam logic [1:0] REG_SURFACE_WIDTH = 2'd0;
  localparam logic [1:0] REG_SURFACE_HEIGHT = 2'd1;
  localparam logic [1:0] REG_FIT_TO_SURFACE = 2'd2;

  localparam int COORD_BITS = 12;
  localparam int GLYPH_DEPTH = 4096;
  localparam int GLYPH_ADDR_BITS = 12;
  localparam int FIXED_CELL_WIDTH = 8;
  localparam logic [11:0] RESET_SURFACE_WIDTH = 12'd640;
  localparam logic [11:0] RESET_SURFACE_HEIGHT = 12'd400;

  typedef struct packed {
    logic [1:0]  kind;
    logic [11:0] font_address;
    logic [7:0]  font_data;
    logic [6:0]  cell_col;
    logic [4:0]  cell_row;
    logic [7:0]  char_code;
    logic [7:0]  attribute;
    logic        blink_phase;
    logic [11:0] pixel_x;
    logic [11:0] pixel_y;
  } in_item_t;

  typedef struct packed {
    logic [3:0] color_index;
    logic       inside_res;
    logic       became_dirty;
    logic       found;
    logic [6:0] dirty_col;
    logic [4:0] dirty_row;
  } out_item_t;

  typedef struct packed {
    logic [1:0]  index;
    logic [11:0] value;
  } cfg_beat_t;

  // One word of the cell memory.
  typedef struct packed {
    logic       dirty;
    logic       blink;
    logic [7:0] attr;
    logic [7:0] code;
  } cell_word_t;

endpackage

FILE: rtl/tmcr_chan_if.sv
// Valid/ready channel interface that carries one payload beat.
interface tmcr_chan_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

FILE: rtl/text_mode_cell_renderer.sv
// Top level of the text cell renderer: cell and glyph memories with their sequencer.
//
// The block keeps a COLUMNS x ROWS text screen and a 4096-byte glyph store.
// Input beats arrive on in_i and carry one of four item kinds: a glyph byte
// write, a cell write, a pixel query or a dirty scan. Every item yields exactly
// one result beat on out_o unless a register write cuts it short. Surface
// width, surface height and the fit mode are written on cfg_i, which is always
// ready; a write to a known register clears every cell and marks it dirty.
// Items are handled one at a time. A cell write reads the cell memory before
// it writes the cell. A pixel query runs up to four divisions on the shared radix-2
// divider, reads the cell memory during the last division and the glyph
// memory after it. A dirty scan reads one cell per cycle from the start of the
// screen until it finds a dirty cell or reaches the last one.
// After reset and after each register write the block sweeps the cell memory,
// one cell per cycle, then computes the cell geometry in ST_SETW, ST_SETH and
// ST_SETB; in_i is not ready until then. A finished result waits in the output
// register; the next item is accepted meanwhile, and the block only stalls
// when a second result is ready before the first beat has been taken.
module text_mode_cell_renderer #(
  parameter int COLUMNS      = 80,
  parameter int ROWS         = 25,
  parameter int GLYPH_HEIGHT = 16
) (
  input logic          clk_i,
  input logic          rst_ni,
  tmcr_chan_if.sink    cfg_i,
  tmcr_chan_if.sink    in_i,
  tmcr_chan_if.source  out_o
);
  import tmcr_pkg::*;

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AB    = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int CW    = COORD_BITS;
  // Room for an offset scaled by the glyph height (at most 64).
  localparam int DW    = COORD_BITS + 6;
  localparam int CB    = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int RB    = (ROWS > 1) ? $clog2(ROWS) : 1;
  // Reciprocals of the cell counts; with these shifts the quotient is exact
  // for every surface size that fits in CW bits.
  localparam int PW    = 2 * CW + 1;
  localparam int SX    = CW + $clog2(COLUMNS);
  localparam int SY    = CW + $clog2(ROWS);
  localparam longint RX = ((longint'(1) << SX) + longint'(COLUMNS) - 1) / longint'(COLUMNS);
  localparam longint RY = ((longint'(1) << SY) + longint'(ROWS) - 1) / longint'(ROWS);
  localparam logic [PW-1:0] RECIP_X = PW'(RX);
  localparam logic [PW-1:0] RECIP_Y = PW'(RY);

  localparam logic [3:0] ST_CLR     = 4'd0;
  localparam logic [3:0] ST_SETW    = 4'd1;
  localparam logic [3:0] ST_SETH    = 4'd2;
  localparam logic [3:0] ST_SETB    = 4'd3;
  localparam logic [3:0] ST_IDLE    = 4'd4;
  localparam logic [3:0] ST_CW_CHK  = 4'd5;
  localparam logic [3:0] ST_PX_X    = 4'd6;
  localparam logic [3:0] ST_PX_Y    = 4'd7;
  localparam logic [3:0] ST_PX_SX   = 4'd8;
  localparam logic [3:0] ST_PX_SY   = 4'd9;
  localparam logic [3:0] ST_PX_GLY  = 4'd10;
  localparam logic [3:0] ST_SC_CHK  = 4'd11;
  localparam logic [3:0] ST_DONE    = 4'd12;

  logic [3:0]    state_q, state_d;
  logic [CW-1:0] width_q, width_d, height_q, height_d;
  logic          fit_q, fit_d;
  // Per axis: pixels below big_* fall in cells base_*+1 wide, the rest in cells base_* wide.
  logic [DW-1:0] base_x_q, base_x_d, extra_x_q, extra_x_d, big_x_q, big_x_d;
  logic [DW-1:0] base_y_q, base_y_d, extra_y_q, extra_y_d, big_y_q, big_y_d;
  in_item_t      item_q, item_d;
  logic          low_q, low_d;
  logic [DW-1:0] cx_q, cx_d, ox_q, ox_d, wx_q, wx_d;
  logic [DW-1:0] cy_q, cy_d, oy_q, oy_d, hy_q, hy_d;
  logic [2:0]    bit_q, bit_d;
  logic [AB-1:0] addr_q, addr_d;
  logic [CB-1:0] scan_col_q, scan_col_d;
  logic [RB-1:0] scan_row_q, scan_row_d;
  out_item_t     pend_q, pend_d, out_q, out_d;
  logic          out_valid_q, out_valid_d;

  // Memories and their ports.
  cell_word_t    cell_mem [CELLS];
  cell_word_t    cell_rd_q;
  logic          cell_re, cell_we;
  logic [AB-1:0] cell_raddr, cell_waddr;
  cell_word_t    cell_wdata;
  logic [7:0]    glyph_mem [GLYPH_DEPTH];
  logic [7:0]    glyph_rd_q;
  logic          glyph_re, glyph_we;
  logic [GLYPH_ADDR_BITS-1:0] glyph_raddr, glyph_waddr;
  logic [7:0]    glyph_wdata;

  // Divider.
  logic          div_start, div_flush, div_done;
  logic [DW-1:0] div_num, div_den, div_quot, div_rem;

  tmcr_div #(.W(DW)) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .flush_i(div_flush),
    .num_i  (div_num),
    .den_i  (div_den),
    .done_o (div_done),
    .quot_o (div_quot),
    .rem_o  (div_rem)
  );

  assign in_i.ready  = (state_q == ST_IDLE);
  assign cfg_i.ready = 1'b1;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  // Scratch values of the sequencer.
  logic [DW-1:0] px, py, cidx;
  logic [PW-1:0] prod_x, prod_y;
  logic [2:0]    back;
  logic [3:0]    fore;
  logic          mark, glyph_bit, cfg_hit;

  always_comb begin
    state_d     = state_q;
    width_d     = width_q;
    height_d    = height_q;
    fit_d       = fit_q;
    base_x_d    = base_x_q;
    extra_x_d   = extra_x_q;
    big_x_d     = big_x_q;
    base_y_d    = base_y_q;
    extra_y_d   = extra_y_q;
    big_y_d     = big_y_q;
    item_d      = item_q;
    low_d       = low_q;
    cx_d        = cx_q;
    ox_d        = ox_q;
    wx_d        = wx_q;
    cy_d        = cy_q;
    oy_d        = oy_q;
    hy_d        = hy_q;
    bit_d       = bit_q;
    addr_d      = addr_q;
    scan_col_d  = scan_col_q;
    scan_row_d  = scan_row_q;
    pend_d      = pend_q;
    out_d       = out_q;
    out_valid_d = out_valid_q & ~out_o.ready;

    cell_re     = 1'b0;
    cell_raddr  = addr_q;
    cell_we     = 1'b0;
    cell_waddr  = addr_q;
    cell_wdata  = cell_rd_q;
    glyph_re    = 1'b0;
    glyph_raddr = '0;
    glyph_we    = 1'b0;
    glyph_waddr = in_i.data.font_address;
    glyph_wdata = in_i.data.font_data;

    div_start = 1'b0;
    div_flush = 1'b0;
    div_num   = '0;
    div_den   = '0;

    px = DW'(CW'(in_i.data.pixel_x));
    py = DW'(CW'(item_q.pixel_y));
    prod_x = PW'(width_q) * RECIP_X;
    prod_y = PW'(height_q) * RECIP_Y;
    cidx = '0;
    back = cell_rd_q.attr[6:4];
    fore = (cell_rd_q.attr[7] && cell_rd_q.blink) ? {1'b0, back} : cell_rd_q.attr[3:0];
    glyph_bit = glyph_rd_q[bit_q];
    mark = (cell_rd_q.attr != item_q.attribute) || (cell_rd_q.code != item_q.char_code) ||
           ((cell_rd_q.blink != item_q.blink_phase) && cell_rd_q.attr[7]);
    cfg_hit = 1'b0;

    case (state_q)
      ST_CLR: begin
        // Sweep: every cell blank and dirty.
        cell_we    = 1'b1;
        cell_wdata = '{dirty: 1'b1, blink: 1'b0, attr: 8'd0, code: 8'd0};
        if (addr_q == AB'(CELLS - 1)) begin
          state_d = ST_SETW;
        end else begin
          addr_d = addr_q + 1'b1;
        end
      end

      ST_SETW: begin
        // Base size per axis: surface size over cell count if fitting, else the glyph size.
        if (fit_q) begin
          base_x_d = DW'(prod_x >> SX);
          base_y_d = DW'(prod_y >> SY);
        end else begin
          base_x_d = DW'(FIXED_CELL_WIDTH);
          base_y_d = DW'(GLYPH_HEIGHT);
        end
        state_d = ST_SETH;
      end

      ST_SETH: begin
        // The remainder goes to the first cells, one extra pixel each.
        if (fit_q) begin
          extra_x_d = DW'(width_q) - DW'(32'(base_x_q) * COLUMNS);
          extra_y_d = DW'(height_q) - DW'(32'(base_y_q) * ROWS);
        end else begin
          extra_x_d = '0;
          extra_y_d = '0;
        end
        state_d = ST_SETB;
      end

      ST_SETB: begin
        // The product never exceeds the surface size, so it fits.
        big_x_d = extra_x_q * (base_x_q + DW'(1));
        big_y_d = extra_y_q * (base_y_q + DW'(1));
        state_d = ST_IDLE;
      end

      ST_IDLE: begin
        if (in_i.valid) begin
          item_d = in_i.data;
          pend_d = '0;
          case (in_i.data.kind)
            KIND_FONT_WRITE: begin
              glyph_we = 1'b1;
              state_d  = ST_DONE;
            end
            KIND_CELL_WRITE: begin
              if (32'(in_i.data.cell_col) >= COLUMNS || 32'(in_i.data.cell_row) >= ROWS) begin
                state_d = ST_DONE;
              end else begin
                addr_d     = AB'(32'(in_i.data.cell_row) * COLUMNS + 32'(in_i.data.cell_col));
                cell_re    = 1'b1;
                cell_raddr = addr_d;
                state_d    = ST_CW_CHK;
              end
            end
            KIND_PIXEL_QUERY: begin
              if (px >= DW'(width_q) ||
                  DW'(CW'(in_i.data.pixel_y)) >= DW'(height_q)) begin
                state_d = ST_DONE;
              end else begin
                div_start = 1'b1;
                if (px < big_x_q) begin
                  low_d   = 1'b1;
                  div_num = px;
                  div_den = base_x_q + DW'(1);
                end else begin
                  low_d   = 1'b0;
                  div_num = px - big_x_q;
                  div_den = base_x_q;
                end
                state_d = ST_PX_X;
              end
            end
            default: begin
              // Dirty scan starts at the first cell.
              addr_d     = '0;
              scan_col_d = '0;
              scan_row_d = '0;
              cell_re    = 1'b1;
              cell_raddr = '0;
              state_d    = ST_SC_CHK;
            end
          endcase
        end
      end

      ST_CW_CHK: begin
        cell_we    = 1'b1;
        cell_wdata = '{dirty: cell_rd_q.dirty | mark, blink: item_q.blink_phase,
                       attr: item_q.attribute, code: item_q.char_code};
        pend_d.became_dirty = mark;
        state_d = ST_DONE;
      end

      ST_PX_X: begin
        if (div_done) begin
          cidx = low_q ? div_quot : div_quot + extra_x_q;
          if (32'(cidx) >= COLUMNS) begin
            state_d = ST_DONE;
          end else begin
            cx_d      = cidx;
            ox_d      = div_rem;
            wx_d      = low_q ? base_x_q + DW'(1) : base_x_q;
            div_start = 1'b1;
            if (py < big_y_q) begin
              low_d   = 1'b1;
              div_num = py;
              div_den = base_y_q + DW'(1);
            end else begin
              low_d   = 1'b0;
              div_num = py - big_y_q;
              div_den = base_y_q;
            end
            state_d = ST_PX_Y;
          end
        end
      end

      ST_PX_Y: begin
        if (div_done) begin
          cidx = low_q ? div_quot : div_quot + extra_y_q;
          if (32'(cidx) >= ROWS) begin
            state_d = ST_DONE;
          end else begin
            cy_d      = cidx;
            oy_d      = div_rem;
            hy_d      = low_q ? base_y_q + DW'(1) : base_y_q;
            // Pixel column inside the glyph.
            div_start = 1'b1;
            div_num   = DW'(ox_q * DW'(FIXED_CELL_WIDTH));
            div_den   = wx_q;
            state_d   = ST_PX_SX;
          end
        end
      end

      ST_PX_SX: begin
        if (div_done) begin
          bit_d      = div_quot[2:0];
          // Scanline inside the glyph; the cell read overlaps it.
          div_start  = 1'b1;
          div_num    = DW'(oy_q * DW'(GLYPH_HEIGHT));
          div_den    = hy_q;
          cell_re    = 1'b1;
          cell_raddr = AB'(cy_q * COLUMNS + cx_q);
          state_d    = ST_PX_SY;
        end
      end

      ST_PX_SY: begin
        if (div_done) begin
          glyph_re    = 1'b1;
          glyph_raddr = GLYPH_ADDR_BITS'(32'(cell_rd_q.code) * GLYPH_HEIGHT + 32'(div_quot));
          state_d     = ST_PX_GLY;
        end
      end

      ST_PX_GLY: begin
        // A clear glyph bit is foreground.
        pend_d.color_index = glyph_bit ? {1'b0, back} : fore;
        pend_d.inside_res  = 1'b1;
        state_d = ST_DONE;
      end

      ST_SC_CHK: begin
        if (cell_rd_q.dirty) begin
          cell_we          = 1'b1;
          cell_wdata       = cell_rd_q;
          cell_wdata.dirty = 1'b0;
          pend_d.found     = 1'b1;
          pend_d.dirty_col = 7'(scan_col_q);
          pend_d.dirty_row = 5'(scan_row_q);
          state_d = ST_DONE;
        end else if (addr_q == AB'(CELLS - 1)) begin
          state_d = ST_DONE;
        end else begin
          addr_d     = addr_q + 1'b1;
          cell_re    = 1'b1;
          cell_raddr = addr_d;
          if (scan_col_q == CB'(COLUMNS - 1)) begin
            scan_col_d = '0;
            scan_row_d = scan_row_q + 1'b1;
          end else begin
            scan_col_d = scan_col_q + 1'b1;
          end
        end
      end

      ST_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          out_d       = pend_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // Register writes; a known register restarts the sweep.
    if (cfg_i.valid) begin
      case (cfg_i.data.index)
        REG_SURFACE_WIDTH: begin
          width_d = CW'(cfg_i.data.value);
          cfg_hit = 1'b1;
        end
        REG_SURFACE_HEIGHT: begin
          height_d = CW'(cfg_i.data.value);
          cfg_hit  = 1'b1;
        end
        REG_FIT_TO_SURFACE: begin
          fit_d   = cfg_i.data.value[0];
          cfg_hit = 1'b1;
        end
        default: begin
          cfg_hit = 1'b0;
        end
      endcase
      if (cfg_hit) begin
        state_d   = ST_CLR;
        addr_d    = '0;
        div_flush = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLR;
      addr_q      <= '0;
      width_q     <= CW'(RESET_SURFACE_WIDTH);
      height_q    <= CW'(RESET_SURFACE_HEIGHT);
      fit_q       <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      addr_q      <= addr_d;
      width_q     <= width_d;
      height_q    <= height_d;
      fit_q       <= fit_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    base_x_q   <= base_x_d;
    extra_x_q  <= extra_x_d;
    big_x_q    <= big_x_d;
    base_y_q   <= base_y_d;
    extra_y_q  <= extra_y_d;
    big_y_q    <= big_y_d;
    item_q     <= item_d;
    low_q      <= low_d;
    cx_q       <= cx_d;
    ox_q       <= ox_d;
    wx_q       <= wx_d;
    cy_q       <= cy_d;
    oy_q       <= oy_d;
    hy_q       <= hy_d;
    bit_q      <= bit_d;
    scan_col_q <= scan_col_d;
    scan_row_q <= scan_row_d;
    pend_q     <= pend_d;
    out_q      <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (cell_we) begin
      cell_mem[cell_waddr] <= cell_wdata;
    end
    if (cell_re) begin
      cell_rd_q <= cell_mem[cell_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (glyph_we) begin
      glyph_mem[glyph_waddr] <= glyph_wdata;
    end
    if (glyph_re) begin
      glyph_rd_q <= glyph_mem[glyph_raddr];
    end
  end
endmodule

FILE: rtl/tmcr_div.sv
// Restoring divider that produces one quotient bit per cycle.
module tmcr_div #(
  parameter int W = 18
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic         flush_i,
  input  logic [W-1:0] num_i,
  input  logic [W-1:0] den_i,
  output logic         done_o,
  output logic [W-1:0] quot_o,
  output logic [W-1:0] rem_o
);
  localparam int CNT_BITS = $clog2(W + 1);

  logic [W-1:0]        quo_q, rem_q, den_q;
  logic [CNT_BITS-1:0] cnt_q;
  logic                active_q, done_q;
  logic [W:0]          rem_sh, diff;
  logic                ge;

  always_comb begin
    rem_sh = {rem_q, quo_q[W-1]};
    diff   = rem_sh - {1'b0, den_q};
    ge     = rem_sh >= {1'b0, den_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      done_q   <= 1'b0;
      cnt_q    <= '0;
    end else if (flush_i) begin
      active_q <= 1'b0;
      done_q   <= 1'b0;
    end else if (start_i) begin
      active_q <= 1'b1;
      done_q   <= 1'b0;
      cnt_q    <= CNT_BITS'(W);
    end else if (active_q) begin
      cnt_q  <= cnt_q - 1'b1;
      done_q <= (cnt_q == CNT_BITS'(1));
      if (cnt_q == CNT_BITS'(1)) begin
        active_q <= 1'b0;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (active_q) begin
      quo_q <= {quo_q[W-2:0], ge};
      rem_q <= ge ? diff[W-1:0] : rem_sh[W-1:0];
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;
  assign rem_o  = rem_q;
endmodule
